// File: rtl/mpel_pkg.sv
package mpel_pkg;

    // paddle element codes
    localparam logic [1:0] ELEM_NONE = 2'd0;
    localparam logic [1:0] ELEM_DIT  = 2'd1;
    localparam logic [1:0] ELEM_DAH  = 2'd2;

    // pressed pair with both paddles down
    localparam logic [1:0] BOTH_MASK = 2'b11;

    // keyer modes (value 3 acts as iambic b)
    localparam logic [1:0] MODE_IAMBIC_A  = 2'd0;
    localparam logic [1:0] MODE_IAMBIC_B  = 2'd1;
    localparam logic [1:0] MODE_ULTIMATIC = 2'd2;

    // request types
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_FETCH  = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // register index of keyer_mode
    localparam logic REG_KEYER_MODE = 1'b0;

    // configuration seen by the core
    typedef struct packed {
        logic [1:0] mode;
        logic       clear;
    } cfg_t;

    // element status carried to the result word
    typedef struct packed {
        logic [1:0] current_element;
        logic [1:0] next_element;
        logic       touched;
    } status_t;

    // dah for dah-less, dit for dah
    function automatic logic [1:0] opposite_of(input logic [1:0] el);
        logic [1:0] res;
        res = (el == ELEM_DAH) ? ELEM_DIT : ELEM_DAH;
        return res;
    endfunction

endpackage

// File: rtl/morse_paddle_element_latch_unit.sv
// channel   | dir | fields (low bit first)
// s_axis    | in  | req_type[1:0], left_contact_n[2], right_contact_n[3]
// m_axis    | out | current_element[1:0], next_element[3:2], touched[4]
// apb       | in  | keyer_mode at byte address 0
//
// one word per cycle while the result is not stalled; each word gives one result word
// path: input register, element state update, result register
// rst_n clears the element state, keyer_mode and both valid flags
// a stalled result holds; the input register keeps taking words while the
// result register is free or being taken in the same cycle
module morse_paddle_element_latch_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // req_type[1:0], left_contact_n[2], right_contact_n[3]
    // status stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // current_element[1:0], next_element[3:2], touched[4]
);

    mpel_pkg::cfg_t    cfg;
    mpel_pkg::status_t status_next;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [3:0]        in_data_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    mpel_pkg::status_t out_data_reg;
    logic              advance;
    logic              s_fire;

    mpel_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // pipeline control
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next  = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : ((m_axis_tready) ? 1'b0 : out_valid_reg);
    end

    mpel_core u_core
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .step_en         (advance),
        .req_type        (in_data_reg[1:0]),
        .left_contact_n  (in_data_reg[2]),
        .right_contact_n (in_data_reg[3]),
        .status_next     (status_next)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_data_reg <= s_axis_tdata[3:0];
        end
        if (advance)
        begin
            out_data_reg <= status_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, out_data_reg.touched, out_data_reg.next_element,
                            out_data_reg.current_element};

endmodule

// File: rtl/mpel_regs.sv
module mpel_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output mpel_pkg::cfg_t      cfg
);

    logic [1:0] mode_reg;
    logic [1:0] mode_next;
    logic       wr_en;

    // write strobe for keyer_mode
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == mpel_pkg::REG_KEYER_MODE);

    always_comb
    begin
        mode_next = mode_reg;
        if (wr_en)
        begin
            mode_next = pwdata[1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= mpel_pkg::MODE_IAMBIC_A;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    // a changed mode clears the element state but not the touched flag
    assign cfg.mode  = mode_reg;
    assign cfg.clear = wr_en && (pwdata[1:0] != mode_reg);

    // read back
    assign prdata = (paddr[2] == mpel_pkg::REG_KEYER_MODE) ? {30'd0, mode_reg} : 32'd0;

endmodule

// File: rtl/mpel_core.sv
module mpel_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  mpel_pkg::cfg_t      cfg,
    input  logic                step_en,
    input  logic [1:0]          req_type,
    input  logic                left_contact_n,
    input  logic                right_contact_n,
    output mpel_pkg::status_t   status_next
);

    logic [1:0] last_reg;
    logic [1:0] last_next;
    logic [1:0] latch_reg;
    logic [1:0] latch_next;
    logic [1:0] cur_reg;
    logic [1:0] cur_next;
    logic [1:0] nxt_reg;
    logic [1:0] nxt_next;
    logic       touch_reg;
    logic       touch_next;
    logic [1:0] pressed;
    logic [1:0] latch_upd;
    logic       is_ult;

    assign pressed = {~right_contact_n, ~left_contact_n};
    assign is_ult  = (cfg.mode == mpel_pkg::MODE_ULTIMATIC);

    // new ultimatic latch: first press, or last-pressed wins
    always_comb
    begin
        if (latch_reg == 2'd0)
        begin
            latch_upd = (pressed == mpel_pkg::BOTH_MASK) ? mpel_pkg::ELEM_DAH : pressed;
        end
        else
        begin
            latch_upd = (latch_reg ^ pressed) & pressed;
        end
    end

    // next state for one request
    always_comb
    begin
        last_next  = last_reg;
        latch_next = latch_reg;
        cur_next   = cur_reg;
        nxt_next   = nxt_reg;
        touch_next = touch_reg;
        if (step_en)
        begin
            unique case (req_type)
                mpel_pkg::REQ_SAMPLE:
                begin
                    if (pressed != last_reg)
                    begin
                        if (pressed != 2'd0)
                        begin
                            touch_next = 1'b1;
                        end
                        priority if (is_ult && (latch_reg != pressed))
                        begin
                            latch_next = latch_upd;
                            nxt_next   = latch_upd;
                        end
                        else if (pressed == mpel_pkg::BOTH_MASK)
                        begin
                            nxt_next = (cur_reg == mpel_pkg::ELEM_NONE)
                                     ? mpel_pkg::ELEM_DAH
                                     : mpel_pkg::opposite_of(cur_reg);
                        end
                        else if (pressed == 2'd0)
                        begin
                            if (cfg.mode == mpel_pkg::MODE_IAMBIC_A)
                            begin
                                nxt_next = mpel_pkg::ELEM_NONE;
                            end
                        end
                        else
                        begin
                            nxt_next = pressed;
                        end
                        last_next = pressed;
                    end
                end
                mpel_pkg::REQ_FETCH:
                begin
                    cur_next = nxt_reg;
                    if ((last_reg == mpel_pkg::BOTH_MASK) && !is_ult)
                    begin
                        nxt_next = mpel_pkg::opposite_of(nxt_reg);
                    end
                end
                mpel_pkg::REQ_CLEAR:
                begin
                    touch_next = 1'b0;
                end
                default:
                begin
                    touch_next = touch_reg;
                end
            endcase
        end
    end

    // element state, cleared on a mode change except for the touched flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= 2'd0;
            latch_reg <= 2'd0;
            cur_reg   <= mpel_pkg::ELEM_NONE;
            nxt_reg   <= mpel_pkg::ELEM_NONE;
            touch_reg <= 1'b0;
        end
        else if (cfg.clear)
        begin
            last_reg  <= 2'd0;
            latch_reg <= 2'd0;
            cur_reg   <= mpel_pkg::ELEM_NONE;
            nxt_reg   <= mpel_pkg::ELEM_NONE;
        end
        else
        begin
            last_reg  <= last_next;
            latch_reg <= latch_next;
            cur_reg   <= cur_next;
            nxt_reg   <= nxt_next;
            touch_reg <= touch_next;
        end
    end

    assign status_next.current_element = cur_next;
    assign status_next.next_element    = nxt_next;
    assign status_next.touched         = touch_next;

endmodule
